[rtl/rpps_pkg.sv]
// shared types and helpers for the ranked pair priority select block
package rpps_pkg;

   localparam int unsigned VALUE_W = 16;

   typedef logic [VALUE_W-1:0] value_type;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_MAX    = 2'd2,
      OP_MIN    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_FIRST  = 2'd0,
      ST_SECOND = 2'd1,
      ST_MEAN   = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic       valid;
      value_type  value;
      status_type status;
   } done_type;

   function automatic value_type mean_up(input value_type a, input value_type b);
      logic [VALUE_W:0] sum;
      sum = {1'b0, a} + {1'b0, b} + {{VALUE_W{1'b0}}, 1'b1};
      return sum[VALUE_W:1];
   endfunction

endpackage

[rtl/rpps_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module rpps_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rpps_ctrl.sv]
// sequencer: list count, ram access and the scan for a matching entry
module rpps_ctrl import rpps_pkg::*; #(
   parameter int unsigned MAX_RANKS = 64,
   localparam int unsigned ADDR_W = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1,
   localparam int unsigned CNT_W  = $clog2(MAX_RANKS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  opcode_type        req_op,
   input  value_type         req_entry,
   input  value_type         req_first,
   input  value_type         req_second,
   input  logic              out_free,
   output done_type          done,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output value_type         ram_wr_data,
   output logic [ADDR_W-1:0] ram_rd_addr,
   input  value_type         ram_rd_data
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              down_ff, down_in;
   value_type         first_ff, first_in;
   value_type         second_ff, second_in;
   logic              accept;

   assign req_ready   = (state_ff == S_IDLE) && out_free;
   assign accept      = req_valid && req_ready;
   assign ram_wr_addr = count_ff[ADDR_W-1:0];
   assign ram_wr_data = req_entry;
   assign ram_rd_addr = addr_in;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      remain_in  = remain_ff;
      addr_in    = addr_ff;
      down_in    = down_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      ram_wr_en  = 1'b0;
      done       = '0;
      done.status = ST_FIRST;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_CLEAR: begin
                     count_in   = '0;
                     done.valid = 1'b1;
                  end
                  OP_APPEND: begin
                     done.valid = 1'b1;
                     if (count_ff < CNT_W'(MAX_RANKS)) begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end else begin
                        done.status = ST_FULL;
                     end
                  end
                  OP_MAX, OP_MIN: begin
                     first_in  = req_first;
                     second_in = req_second;
                     down_in   = (req_op == OP_MIN);
                     if (count_ff == '0) begin
                        done.valid  = 1'b1;
                        done.value  = mean_up(req_first, req_second);
                        done.status = ST_MEAN;
                     end else begin
                        remain_in = count_ff;
                        addr_in   = (req_op == OP_MIN) ?
                                    ADDR_W'(count_ff - CNT_W'(1)) : '0;
                        state_in  = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (ram_rd_data == first_ff) begin
               done.valid  = 1'b1;
               done.value  = first_ff;
               done.status = ST_FIRST;
               state_in    = S_IDLE;
            end else if (ram_rd_data == second_ff) begin
               done.valid  = 1'b1;
               done.value  = second_ff;
               done.status = ST_SECOND;
               state_in    = S_IDLE;
            end else if (remain_ff == CNT_W'(1)) begin
               done.valid  = 1'b1;
               done.value  = mean_up(first_ff, second_ff);
               done.status = ST_MEAN;
               state_in    = S_IDLE;
            end else begin
               remain_in = remain_ff - CNT_W'(1);
               addr_in   = down_ff ? (addr_ff - ADDR_W'(1)) : (addr_ff + ADDR_W'(1));
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
      end
      addr_ff   <= addr_in;
      down_ff   <= down_in;
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RANKS))
      else $error("entry count beyond list depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (remain_ff != '0) && (remain_ff <= count_ff))
      else $error("scan window outside the list");

   a_done_source: assert property (@(posedge clock) disable iff (reset)
      done.valid |-> (accept || (state_ff == S_SCAN)))
      else $error("result produced with no item in progress");

   a_done_room: assert property (@(posedge clock) disable iff (reset)
      done.valid |-> out_free)
      else $error("result produced while output register busy");

endmodule

[rtl/ranked_pair_priority_select.sv]
// top level of the ranked pair priority select block
//
// keeps a ranked list of up to MAX_RANKS 16-bit entries, entry 0 ranked highest.
// req channel: one item per handshake; req_tuser carries the opcode (clear,
// append, max-rank query, min-rank query), req_tdata the entry and two contenders.
// rsp channel: exactly one item per request, carrying the chosen value and a
// status (first matched or ok, second matched, mean used, append dropped full).
// clear, append and a query on an empty list finish in the accept cycle and
// show on rsp in the cycle after. a query on n entries reads the list ram one entry
// per cycle until a match or until all n entries are read, and its response is
// then registered; the single read port of the list ram sets that rate.
// one item is in flight at a time: req_tready is high while the sequencer is
// idle and the output register is empty or being taken.
// a stalled rsp holds its item and keeps req_tready low until it is taken.
// reset empties the list at once; entry contents are kept but never read.
module ranked_pair_priority_select import rpps_pkg::*; #(
   parameter int unsigned MAX_RANKS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // entry_value, first_value, second_value
   input  logic [1:0]  req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // chosen_value
   output logic [1:0]  rsp_tuser   // status
);

   localparam int unsigned ADDR_W = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;

   done_type          done;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   value_type         ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   value_type         ram_rd_data;
   logic              out_free;
   logic              rsp_valid_ff, rsp_valid_in;
   value_type         rsp_value_ff, rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;

   assign out_free = !rsp_valid_ff || rsp_tready;

   rpps_ctrl #(
      .MAX_RANKS (MAX_RANKS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (opcode_type'(req_tuser)),
      .req_entry   (req_tdata[15:0]),
      .req_first   (req_tdata[31:16]),
      .req_second  (req_tdata[47:32]),
      .out_free    (out_free),
      .done        (done),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   rpps_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_RANKS)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = done.value;
         rsp_status_in = done.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready || rsp_valid_ff)
      else $error("second item taken before the first one finished");

   a_full_only_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FULL)) |-> (rsp_value_ff == '0))
      else $error("dropped append reports a nonzero value");

   a_no_ready_while_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while response is stalled");

endmodule

[dv/ranked_pair_priority_select_test.sv]
// self-checking testbench for the ranked pair priority select block
module ranked_pair_priority_select_test import rpps_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_RANKS = 64;
   localparam int PHASE_ITEMS = 135;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      opcode_type op;
      value_type  entry;
      value_type  first;
      value_type  second;
      logic       fixed;
      value_type  want_value;
      status_type want_status;
   } probe_row_type;

   typedef struct packed {
      value_type  value;
      status_type status;
   } outcome_type;

   localparam int N_DIRECTED = 14;
   localparam probe_row_type DIRECTED [N_DIRECTED] = '{
      '{OP_MAX,    16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, ST_MEAN},
      '{OP_MIN,    16'hFFFF, 16'h0000, 16'h0000, 1'b1, 16'h0000, ST_MEAN},
      '{OP_MAX,    16'h0000, 16'hFFFF, 16'h0000, 1'b1, 16'h8000, ST_MEAN},
      '{OP_APPEND, 16'h1234, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, ST_FIRST},
      '{OP_APPEND, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 16'h0000, ST_FIRST},
      '{OP_APPEND, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, ST_FIRST},
      '{OP_APPEND, 16'h1234, 16'h0000, 16'h0000, 1'b1, 16'h0000, ST_FIRST},
      '{OP_MAX,    16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, ST_FIRST},
      '{OP_MIN,    16'h0000, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, ST_FIRST},
      '{OP_MAX,    16'h0000, 16'h1234, 16'h1234, 1'b0, 16'h0000, ST_FIRST},
      '{OP_MIN,    16'h0000, 16'h5555, 16'h1234, 1'b0, 16'h0000, ST_FIRST},
      '{OP_MAX,    16'h0000, 16'hAAAA, 16'h5555, 1'b0, 16'h0000, ST_FIRST},
      '{OP_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, ST_FIRST},
      '{OP_MIN,    16'h0000, 16'h1234, 16'hFFFF, 1'b1, 16'h891A, ST_MEAN}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // entry_value, first_value, second_value
   logic [1:0]  req_tuser = '0;  // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // chosen_value
   logic [1:0]  rsp_tuser;       // status

   value_type   rank_store [MAX_RANKS];
   int          rank_fill = 0;
   outcome_type pending_results [$];
   int          send_gap_pct = 0;
   int          rsp_stall_pct = 0;
   int          error_count = 0;
   int          items_sent = 0;
   int          clear_count = 0;
   int          append_count = 0;
   int          query_by_status [4] = '{0, 0, 0, 0};

   ranked_pair_priority_select #(.MAX_RANKS(MAX_RANKS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic outcome_type select_outcome(input probe_row_type r);
      outcome_type o;
      logic        hit;
      int          idx;
      logic [16:0] total;
      o = '{value: '0, status: ST_FIRST};
      hit = 1'b0;
      case (r.op)
         OP_CLEAR: begin
            rank_fill = 0;
            clear_count++;
         end
         OP_APPEND: begin
            append_count++;
            if (rank_fill < MAX_RANKS) begin
               rank_store[rank_fill] = r.entry;
               rank_fill++;
            end else begin
               o.status = ST_FULL;
               query_by_status[ST_FULL]++;
            end
         end
         default: begin
            for (int k = 0; k < rank_fill && !hit; k++) begin
               idx = (r.op == OP_MAX) ? k : rank_fill - 1 - k;
               if (rank_store[idx] == r.first) begin
                  o = '{value: r.first, status: ST_FIRST};
                  hit = 1'b1;
               end else if (rank_store[idx] == r.second) begin
                  o = '{value: r.second, status: ST_SECOND};
                  hit = 1'b1;
               end
            end
            if (!hit) begin
               total = {1'b0, r.first} + {1'b0, r.second} + 17'd1;
               o = '{value: total[16:1], status: ST_MEAN};
            end
            query_by_status[o.status]++;
         end
      endcase
      return o;
   endfunction

   task automatic push_item(input probe_row_type r);
      outcome_type o;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {r.second, r.first, r.entry};
      do @(posedge clock); while (!req_tready);
      o = select_outcome(r);
      if (r.fixed)
         o = '{value: r.want_value, status: r.want_status};
      pending_results.push_back(o);
      items_sent++;
   endtask

   function automatic value_type pick_contender();
      if (rank_fill > 0 && $urandom_range(9) < 7)
         return rank_store[$urandom_range(rank_fill - 1)];
      case ($urandom_range(3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return value_type'($urandom);
      endcase
   endfunction

   function automatic probe_row_type random_row(input opcode_type op);
      probe_row_type r;
      r = '{op: op, entry: value_type'($urandom), first: value_type'($urandom),
            second: value_type'($urandom), fixed: 1'b0, want_value: '0,
            want_status: ST_FIRST};
      if (op == OP_APPEND && $urandom_range(3) == 0)
         r.entry = value_type'($urandom_range(7));
      if (op == OP_MAX || op == OP_MIN) begin
         r.first  = pick_contender();
         r.second = ($urandom_range(7) == 0) ? r.first : pick_contender();
      end
      return r;
   endfunction

   // clear, then appends interleaved with queries, with some noise items
   task automatic run_sequence(input int fill, input int queries);
      int appends_left;
      int queries_left;
      appends_left = fill;
      queries_left = queries;
      push_item(random_row(OP_CLEAR));
      while (appends_left + queries_left > 0) begin
         if ($urandom_range(11) == 0) begin
            push_item(random_row(opcode_type'($urandom_range(3))));
         end else if (appends_left > 0 && (queries_left == 0 || $urandom_range(2) != 0)) begin
            push_item(random_row(OP_APPEND));
            appends_left--;
         end else begin
            push_item(random_row($urandom_range(1) ? OP_MAX : OP_MIN));
            queries_left--;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected item chosen_value %h status %0d",
                        $time, rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               if (rsp_tdata !== pending_results[0].value) begin
                  $display("%0t: chosen_value mismatch expected %h actual %h",
                           $time, pending_results[0].value, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser !== pending_results[0].status) begin
                  $display("%0t: status mismatch expected %0d actual %0d",
                           $time, pending_results[0].status, rsp_tuser);
                  error_count++;
               end
               void'(pending_results.pop_front());
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct  = 15;
      rsp_stall_pct = 69;
      for (int i = 0; i < N_DIRECTED; i++)
         push_item(DIRECTED[i]);

      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct  = (phase == 0) ? 15 : (phase == 1) ? 69 : 0;
         rsp_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 15 : 0;
         // overfill so appends hit the full list
         run_sequence(MAX_RANKS + $urandom_range(1, 3), $urandom_range(4, 8));
         while (items_sent < N_DIRECTED + (phase + 1) * PHASE_ITEMS)
            run_sequence($urandom_range(0, 12), $urandom_range(2, 8));
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items: %0d clears, %0d appends (%0d dropped on a full list)",
               items_sent, clear_count, append_count, query_by_status[ST_FULL]);
      $display("queries: %0d first matched, %0d second matched, %0d mean used",
               query_by_status[ST_FIRST], query_by_status[ST_SECOND],
               query_by_status[ST_MEAN]);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
rtl/rpps_pkg.sv
rtl/rpps_ram.sv
rtl/rpps_ctrl.sv
rtl/ranked_pair_priority_select.sv
dv/ranked_pair_priority_select_test.sv
